// File: rtl/pgrs_pkg.sv
package pgrs_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int GAIN_W         = 16;
    localparam int ACC_W          = 32;
    localparam int PROD_W         = SAMPLE_W + ACC_W;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int ACC_FRAC_BITS  = GAIN_FRAC_BITS + 16;
    localparam int DIV_BITS       = 32;
    localparam int DIVISOR_W      = 16;

    localparam logic [1:0] MODE_CONST = 2'd0;
    localparam logic [1:0] MODE_RAMP  = 2'd1;
    localparam logic [1:0] MODE_MONO  = 2'd2;

    localparam logic [2:0] CFG_GAIN_MODE        = 3'd0;
    localparam logic [2:0] CFG_START_GAIN_LEFT  = 3'd1;
    localparam logic [2:0] CFG_START_GAIN_RIGHT = 3'd2;
    localparam logic [2:0] CFG_END_GAIN_LEFT    = 3'd3;
    localparam logic [2:0] CFG_END_GAIN_RIGHT   = 3'd4;
    localparam logic [2:0] CFG_FRAME_COUNT      = 3'd5;
    localparam logic [2:0] CFG_CHANNEL_COUNT    = 3'd6;

    typedef struct packed {
        logic                  start;
        logic                  neg;
        logic [DIV_BITS-1:0]   num_mag;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

endpackage

// File: rtl/pcm_gain_ramp_saturate.sv
// channel | direction | word
// s_axis  | in        | tdata[15:0] sample_in
// m_axis  | out       | tdata[15:0] sample_out, tuser clipped, tlast buffer_end
// cfg     | in        | we, addr[2:0] register index, wdata[15:0]
//
// An item outside a buffer start is accepted with its multiply, then saturated and written back.
// The first sample of every buffer latches the ramp in any mode and is multiplied
// after the latch: directly when frame_count is 0 or 1, or, when it is 2 or more,
// once the shared 32-step divider has computed the left and then the right step.
// A new word is accepted while the last result waits in the output register;
// write back waits until that register is free. Reset is synchronous.
module pcm_gain_ramp_saturate #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [pgrs_pkg::SAMPLE_W-1:0]      i_s_axis_tdata,   // [15:0] sample_in
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [pgrs_pkg::SAMPLE_W-1:0]      o_m_axis_tdata,   // [15:0] sample_out
    output logic                               o_m_axis_tuser,   // [0] clipped
    output logic                               o_m_axis_tlast,
    input  logic                               i_cfg_we,
    input  logic [2:0]                         i_cfg_addr,
    input  logic [pgrs_pkg::GAIN_W-1:0]        i_cfg_wdata
);
    import pgrs_pkg::*;

    localparam int CPW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [4:0] MAXC = 5'(MAX_CHANNELS);
    localparam logic signed [ACC_W-1:0] GAIN_ONE = ACC_W'(1) <<< GAIN_FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIVL = 5'b00010,
        S_DIVR = 5'b00100,
        S_MUL  = 5'b01000,
        S_WB   = 5'b10000
    } t_state;

    t_state r_state;

    logic [1:0]                r_gain_mode;
    logic signed [GAIN_W-1:0]  r_sgl, r_sgr, r_egl, r_egr;
    logic [15:0]               r_frame_count;
    logic [3:0]                r_channel_count;

    logic [CPW-1:0]            r_channel_pos;
    logic [15:0]               r_frame_pos;
    logic signed [ACC_W-1:0]   r_left_acc, r_right_acc, r_left_step, r_right_step;
    logic [SAMPLE_W-1:0]       r_sample;

    logic                      r_out_valid;
    logic [SAMPLE_W-1:0]       r_out_data;
    logic                      r_out_clip;
    logic                      r_out_last;

    logic [4:0]                ch_eff;
    logic [CPW-1:0]            ch_last;
    logic                      pos_end, fc_nz, last, stereo_ok, pos_lt2, latch_need;
    logic                      accept, wb_fire, scale_load, long_shift;
    logic signed [ACC_W-1:0]   gain;
    logic signed [SAMPLE_W-1:0] mul_sample;
    logic signed [SAMPLE_W-1:0] scale_res;
    logic                      scale_clip;
    logic signed [GAIN_W:0]    diff_l, diff_r, diff;
    logic [GAIN_W:0]           abs_diff;
    t_div_req                  div_req;
    logic                      div_done;
    logic signed [ACC_W-1:0]   div_quot;
    logic signed [ACC_W:0]     sum_l, sum_r;
    logic signed [ACC_W-1:0]   acc_l_n, acc_r_n;

    always_comb begin
        if (r_channel_count == 4'd0)
            ch_eff = 5'd1;
        else if ({1'b0, r_channel_count} > MAXC)
            ch_eff = MAXC;
        else
            ch_eff = {1'b0, r_channel_count};
        ch_last    = CPW'(ch_eff - 5'd1);
        pos_end    = r_channel_pos >= ch_last;
        fc_nz      = r_frame_count != 16'd0;
        last       = fc_nz && pos_end && (r_frame_pos >= r_frame_count - 16'd1);
        stereo_ok  = (ch_eff >= 5'd2) && fc_nz;
        pos_lt2    = {1'b0, r_channel_pos} < (CPW+1)'(2);
        latch_need = (r_channel_pos == '0) && (r_frame_pos == 16'd0);
    end

    always_comb begin
        gain       = GAIN_ONE;
        long_shift = 1'b0;
        if (r_gain_mode == MODE_CONST && stereo_ok && pos_lt2) begin
            gain = (r_channel_pos == '0) ? ACC_W'(r_sgl) : ACC_W'(r_sgr);
        end else if (r_gain_mode == MODE_RAMP && stereo_ok && pos_lt2) begin
            gain       = (r_channel_pos == '0) ? r_left_acc : r_right_acc;
            long_shift = 1'b1;
        end else if (r_gain_mode == MODE_MONO) begin
            gain = ACC_W'(r_sgl);
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign wb_fire    = (r_state == S_WB) && (!r_out_valid || i_m_axis_tready);
    assign scale_load = (accept && !latch_need) || (r_state == S_MUL);
    assign mul_sample = (r_state == S_IDLE) ? i_s_axis_tdata : r_sample;

    pgrs_scale u_scale (
        .i_clk       (i_clk),
        .i_load      (scale_load),
        .i_long_shift(long_shift),
        .i_sample    (mul_sample),
        .i_gain      (gain),
        .o_result    (scale_res),
        .o_clip      (scale_clip)
    );

    always_comb begin
        diff_l   = {r_egl[GAIN_W-1], r_egl} - {r_sgl[GAIN_W-1], r_sgl};
        diff_r   = {r_egr[GAIN_W-1], r_egr} - {r_sgr[GAIN_W-1], r_sgr};
        diff     = (r_state == S_DIVL) ? diff_r : diff_l;
        abs_diff = diff[GAIN_W] ? (GAIN_W+1)'(-diff) : diff;
        div_req.start   = (accept && latch_need && r_frame_count >= 16'd2)
                       || (r_state == S_DIVL && div_done);
        div_req.neg     = diff[GAIN_W];
        div_req.num_mag = {abs_diff[GAIN_W-1:0], 16'h0000};
        div_req.divisor = r_frame_count - 16'd1;
    end

    pgrs_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    always_comb begin
        sum_l = {r_left_acc[ACC_W-1], r_left_acc} + {r_left_step[ACC_W-1], r_left_step};
        sum_r = {r_right_acc[ACC_W-1], r_right_acc}
              + {r_right_step[ACC_W-1], r_right_step};
        if (sum_l[ACC_W] != sum_l[ACC_W-1])
            acc_l_n = sum_l[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            acc_l_n = sum_l[ACC_W-1:0];
        if (sum_r[ACC_W] != sum_r[ACC_W-1])
            acc_r_n = sum_r[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            acc_r_n = sum_r[ACC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_mode     <= MODE_CONST;
            r_sgl           <= 16'sd4096;
            r_sgr           <= 16'sd4096;
            r_egl           <= 16'sd4096;
            r_egr           <= 16'sd4096;
            r_frame_count   <= 16'd0;
            r_channel_count <= 4'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_GAIN_MODE:        r_gain_mode     <= i_cfg_wdata[1:0];
                CFG_START_GAIN_LEFT:  r_sgl           <= i_cfg_wdata;
                CFG_START_GAIN_RIGHT: r_sgr           <= i_cfg_wdata;
                CFG_END_GAIN_LEFT:    r_egl           <= i_cfg_wdata;
                CFG_END_GAIN_RIGHT:   r_egr           <= i_cfg_wdata;
                CFG_FRAME_COUNT:      r_frame_count   <= i_cfg_wdata;
                CFG_CHANNEL_COUNT:    r_channel_count <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_channel_pos <= '0;
            r_frame_pos   <= 16'd0;
            r_left_acc    <= '0;
            r_right_acc   <= '0;
            r_left_step   <= '0;
            r_right_step  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (wb_fire)
                r_out_valid <= 1'b1;
            else if (i_m_axis_tready)
                r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!latch_need) begin
                            r_state <= S_WB;
                        end else if (r_frame_count == 16'd1) begin
                            r_left_acc   <= {r_egl, 16'h0000};
                            r_right_acc  <= {r_egr, 16'h0000};
                            r_left_step  <= '0;
                            r_right_step <= '0;
                            r_state      <= S_MUL;
                        end else begin
                            r_left_acc  <= {r_sgl, 16'h0000};
                            r_right_acc <= {r_sgr, 16'h0000};
                            if (!fc_nz) begin
                                r_left_step  <= '0;
                                r_right_step <= '0;
                                r_state      <= S_MUL;
                            end else begin
                                r_state <= S_DIVL;
                            end
                        end
                    end
                end
                S_DIVL: begin
                    if (div_done) begin
                        r_left_step <= div_quot;
                        r_state     <= S_DIVR;
                    end
                end
                S_DIVR: begin
                    if (div_done) begin
                        r_right_step <= div_quot;
                        r_state      <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (wb_fire) begin
                        r_state <= S_IDLE;
                        if (pos_end) begin
                            r_channel_pos <= '0;
                            r_left_acc    <= acc_l_n;
                            r_right_acc   <= acc_r_n;
                            r_frame_pos   <= last ? 16'd0 : r_frame_pos + 16'd1;
                        end else begin
                            r_channel_pos <= r_channel_pos + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept)
            r_sample <= i_s_axis_tdata;
        if (wb_fire) begin
            r_out_data <= scale_res;
            r_out_clip <= scale_clip;
            r_out_last <= last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_clip;
    assign o_m_axis_tlast  = r_out_last;

    a_fast_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !latch_need) |=> (r_state == S_WB))
        else $error("word outside a buffer start did not go to write back");
    a_mul_to_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_WB))
        else $error("multiply not followed by write back");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_channel_pos <= CPW'(MAX_CHANNELS - 1))
        else $error("channel position out of range");

endmodule

// File: rtl/pgrs_div.sv
module pgrs_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pgrs_pkg::t_div_req                   i_req,
    output logic                                 o_done,
    output logic signed [pgrs_pkg::ACC_W-1:0]    o_quot
);
    import pgrs_pkg::*;

    localparam int CNT_W = $clog2(DIV_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_BITS - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_neg;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIV_BITS-1:0]   r_num;
    logic [DIV_BITS-1:0]   r_q;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    trial;
    logic                  q_bit;

    always_comb begin
        rem_sh = {r_rem, r_num[DIV_BITS-1]};
        trial  = rem_sh - {1'b0, r_div};
        q_bit  = !trial[DIVISOR_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.neg;
            r_div <= i_req.divisor;
            r_num <= i_req.num_mag;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_BITS-2:0], 1'b0};
            r_rem <= q_bit ? trial[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            r_q   <= {r_q[DIV_BITS-2:0], q_bit};
        end
    end

    // saturate the quotient magnitude to the signed range
    always_comb begin
        if (r_neg) begin
            if (r_q > {1'b1, {(DIV_BITS-1){1'b0}}})
                o_quot = {1'b1, {(ACC_W-1){1'b0}}};
            else
                o_quot = ACC_W'(-r_q);
        end else begin
            if (r_q[DIV_BITS-1])
                o_quot = {1'b0, {(ACC_W-1){1'b1}}};
            else
                o_quot = ACC_W'(r_q);
        end
    end

    assign o_done = r_done;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("divider started while busy");
    a_busy_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_req.start) |=> (r_busy || r_done))
        else $error("divider dropped a result");

endmodule

// File: rtl/pgrs_scale.sv
module pgrs_scale (
    input  logic                                   i_clk,
    input  logic                                   i_load,
    input  logic                                   i_long_shift,
    input  logic signed [pgrs_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic signed [pgrs_pkg::ACC_W-1:0]      i_gain,
    output logic signed [pgrs_pkg::SAMPLE_W-1:0]   o_result,
    output logic                                   o_clip
);
    import pgrs_pkg::*;

    localparam logic signed [PROD_W-1:0] HI_S = 48'sd32767 <<< GAIN_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] LO_S = -(48'sd32768 <<< GAIN_FRAC_BITS);
    localparam logic signed [PROD_W-1:0] HI_L = 48'sd32767 <<< ACC_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] LO_L = -(48'sd32768 <<< ACC_FRAC_BITS);
    localparam logic [PROD_W-1:0] MASK_S = (48'd1 << GAIN_FRAC_BITS) - 48'd1;
    localparam logic [PROD_W-1:0] MASK_L = (48'd1 << ACC_FRAC_BITS) - 48'd1;

    logic signed [PROD_W-1:0] mul;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_long;
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    logic signed [PROD_W-1:0] adj;
    logic signed [PROD_W-1:0] shifted;
    logic                     neg;

    assign mul = i_sample * i_gain;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= mul;
            r_long <= i_long_shift;
        end
    end

    always_comb begin
        neg     = r_prod[PROD_W-1];
        hi      = r_long ? HI_L : HI_S;
        lo      = r_long ? LO_L : LO_S;
        o_clip  = (r_prod > hi) || (r_prod < lo);
        adj     = r_prod + $signed(neg ? (r_long ? MASK_L : MASK_S) : '0);
        shifted = r_long ? (adj >>> ACC_FRAC_BITS) : (adj >>> GAIN_FRAC_BITS);
        if (o_clip)
            o_result = neg ? 16'sh8000 : 16'sh7FFF;
        else
            o_result = shifted[SAMPLE_W-1:0];
    end

endmodule

// File: sim/tb_pcm_gain_ramp_saturate.sv
module tb_pcm_gain_ramp_saturate;
    timeunit 1ns;
    timeprecision 1ps;

    import pgrs_pkg::*;

    localparam int         MAX_CH      = 8;
    localparam int         WORD_TARGET = 1700;
    localparam int         HOLD_CYCLES = 400;
    localparam int         SETTLE      = 8;
    localparam logic [1:0] MODE_PASS   = 2'd3;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} t_idle;
    typedef enum logic [1:0] {ROW_REG, ROW_WORD, ROW_TYPED} t_row_kind;

    typedef struct packed {
        logic [15:0] sample;
        logic        clipped;
        logic        buf_end;
    } t_pcm_out;

    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  addr;
        logic [15:0] value;
        logic [15:0] exp_smp;
        logic        exp_clip;
        logic        exp_last;
    } t_row;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_valid   = 1'b0;
    logic [15:0] s_data    = '0;
    logic        m_ready   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;
    wire         s_ready;
    wire         m_valid;
    wire  [15:0] m_data;
    wire         m_clip;
    wire         m_last;

    t_idle       idle_mode = IDLE_NONE;
    bit          hold_req  = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_cnt  = 0;

    // register copies and buffer position of the gain stage
    logic [1:0]         cfg_mode    = MODE_CONST;
    logic signed [15:0] cfg_start_l = 16'h1000;
    logic signed [15:0] cfg_start_r = 16'h1000;
    logic signed [15:0] cfg_end_l   = 16'h1000;
    logic signed [15:0] cfg_end_r   = 16'h1000;
    logic [15:0]        cfg_frames  = '0;
    logic [3:0]         cfg_chans   = 4'd2;
    int                 chan_pos    = 0;
    logic [15:0]        frame_pos   = '0;
    int                 l_acc       = 0;
    int                 r_acc       = 0;
    int                 l_step      = 0;
    int                 r_step      = 0;

    t_pcm_out scaled_q[$];
    int n_words   = 0;
    int n_results = 0;
    int n_clipped = 0;
    int n_ends    = 0;
    int n_phases  = 0;
    int n_fail    = 0;

    t_row dir_rows [42] = '{
        '{ROW_TYPED, '0, 16'h8000, 16'h8000, 1'b0, 1'b0},
        '{ROW_TYPED, '0, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0},
        '{ROW_REG, CFG_FRAME_COUNT, 16'd2, '0, 1'b0, 1'b0},
        '{ROW_REG, CFG_START_GAIN_LEFT, 16'h7FFF, '0, 1'b0, 1'b0},
        '{ROW_REG, CFG_START_GAIN_RIGHT, 16'h8000, '0, 1'b0, 1'b0},
        '{ROW_REG, CFG_CHANNEL_COUNT, 16'd3, '0, 1'b0, 1'b0},
        '{ROW_TYPED, '0, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0},
        '{ROW_TYPED, '0, 16'h7FFF, 16'h8000, 1'b1, 1'b0},
        '{ROW_TYPED, '0, 16'h1234, 16'h1234, 1'b0, 1'b1},
        '{ROW_TYPED, '0, 16'h0001, 16'h0007, 1'b0, 1'b0},
        '{ROW_TYPED, '0, 16'hFFFF, 16'h0008, 1'b0, 1'b0},
        '{ROW_TYPED, '0, 16'h0000, 16'h0000, 1'b0, 1'b0},
        '{ROW_TYPED, '0, 16'h8000, 16'h8000, 1'b1, 1'b0},
        '{ROW_TYPED, '0, 16'h8000, 16'h7FFF, 1'b1, 1'b0},
        '{ROW_TYPED, '0, 16'h5555, 16'h5555, 1'b0, 1'b1},
        '{ROW_REG, CFG_GAIN_MODE, {14'd0, MODE_MONO}, '0, 1'b0, 1'b0},
        '{ROW_REG, CFG_START_GAIN_LEFT, 16'h1000, '0, 1'b0, 1'b0},
        '{ROW_REG, CFG_FRAME_COUNT, 16'd0, '0, 1'b0, 1'b0},
        '{ROW_TYPED, '0, 16'h8000, 16'h8000, 1'b0, 1'b0},
        '{ROW_REG, CFG_START_GAIN_LEFT, 16'hF000, '0, 1'b0, 1'b0},
        '{ROW_TYPED, '0, 16'h8000, 16'h7FFF, 1'b1, 1'b0},
        '{ROW_TYPED, '0, 16'h7FFF, 16'h8001, 1'b0, 1'b0},
        '{ROW_REG, CFG_GAIN_MODE, {14'd0, MODE_PASS}, '0, 1'b0, 1'b0},
        '{ROW_TYPED, '0, 16'h8000, 16'h8000, 1'b0, 1'b0},
        '{ROW_REG, CFG_GAIN_MODE, {14'd0, MODE_RAMP}, '0, 1'b0, 1'b0},
        '{ROW_REG, CFG_FRAME_COUNT, 16'd2, '0, 1'b0, 1'b0},
        '{ROW_REG, CFG_CHANNEL_COUNT, 16'd2, '0, 1'b0, 1'b0},
        '{ROW_REG, CFG_START_GAIN_LEFT, 16'h8000, '0, 1'b0, 1'b0},
        '{ROW_REG, CFG_START_GAIN_RIGHT, 16'h7FFF, '0, 1'b0, 1'b0},
        '{ROW_REG, CFG_END_GAIN_LEFT, 16'h7FFF, '0, 1'b0, 1'b0},
        '{ROW_REG, CFG_END_GAIN_RIGHT, 16'h8000, '0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h4000, '0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h7FFF, '0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h8000, '0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h0100, '0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'hC000, '0, 1'b0, 1'b0},
        '{ROW_REG, CFG_FRAME_COUNT, 16'd1, '0, 1'b0, 1'b0},
        '{ROW_REG, CFG_END_GAIN_LEFT, 16'h2000, '0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h3000, '0, 1'b0, 1'b0},
        '{ROW_WORD, '0, 16'h3000, '0, 1'b0, 1'b0},
        '{ROW_REG, CFG_CHANNEL_COUNT, 16'd0, '0, 1'b0, 1'b0},
        '{ROW_TYPED, '0, 16'h4321, 16'h4321, 1'b0, 1'b1}
    };

    pcm_gain_ramp_saturate #(
        .MAX_CHANNELS(MAX_CH)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_clip),
        .o_m_axis_tlast (m_last),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_wdata    (cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic int clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return int'(v);
    endfunction

    function automatic t_pcm_out scale_sat(input logic signed [15:0] smp, input longint gain,
                                           input int sh);
        t_pcm_out res;
        longint   prod;
        longint   mag;
        longint   lim;
        prod = longint'(smp) * gain;
        mag  = (prod < 0) ? -prod : prod;
        lim  = (prod < 0) ? 32768 : 32767;
        res  = '0;
        if (mag > (lim <<< sh)) begin
            res.clipped = 1'b1;
            res.sample  = (prod < 0) ? 16'h8000 : 16'h7FFF;
        end else begin
            res.sample = (prod < 0) ? 16'(-(mag >>> sh)) : 16'(mag >>> sh);
        end
        return res;
    endfunction

    function automatic t_pcm_out apply_gain(input logic signed [15:0] smp);
        t_pcm_out res;
        int       nch;
        bit       stereo;
        longint   a;
        longint   b;
        longint   den;
        nch = cfg_chans;
        if (nch == 0) nch = 1;
        if (nch > MAX_CH) nch = MAX_CH;
        stereo = nch >= 2 && cfg_frames != 0;

        // latch the ramp at the first sample of a buffer
        if (chan_pos == 0 && frame_pos == 0) begin
            den    = cfg_frames;
            l_step = 0;
            r_step = 0;
            if (den == 1) begin
                a = cfg_end_l;
                b = cfg_end_r;
            end else begin
                a = cfg_start_l;
                b = cfg_start_r;
                if (den != 0) begin
                    l_step = clamp32((longint'(cfg_end_l) - a) * 65536 / (den - 1));
                    r_step = clamp32((longint'(cfg_end_r) - b) * 65536 / (den - 1));
                end
            end
            l_acc = clamp32(a * 65536);
            r_acc = clamp32(b * 65536);
        end

        res        = '0;
        res.sample = smp;
        if (cfg_mode == MODE_CONST && stereo && chan_pos < 2)
            res = scale_sat(smp, (chan_pos == 0) ? cfg_start_l : cfg_start_r, GAIN_FRAC_BITS);
        else if (cfg_mode == MODE_RAMP && stereo && chan_pos < 2)
            res = scale_sat(smp, (chan_pos == 0) ? l_acc : r_acc, ACC_FRAC_BITS);
        else if (cfg_mode == MODE_MONO)
            res = scale_sat(smp, cfg_start_l, GAIN_FRAC_BITS);

        res.buf_end = cfg_frames != 0 && chan_pos >= nch - 1 && frame_pos >= cfg_frames - 1;

        if (chan_pos >= nch - 1) begin
            chan_pos  = 0;
            l_acc     = clamp32(longint'(l_acc) + l_step);
            r_acc     = clamp32(longint'(r_acc) + r_step);
            frame_pos = res.buf_end ? 16'd0 : frame_pos + 16'd1;
        end else begin
            chan_pos++;
        end
        return res;
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'h1000;
            4, 5:    return 16'($urandom_range(0, 16'h4000)) - 16'h2000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        if ($urandom_range(7) != 0) return 16'($urandom);
        case ($urandom_range(4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (scaled_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        case (addr)
            CFG_GAIN_MODE:        cfg_mode    = val[1:0];
            CFG_START_GAIN_LEFT:  cfg_start_l = val;
            CFG_START_GAIN_RIGHT: cfg_start_r = val;
            CFG_END_GAIN_LEFT:    cfg_end_l   = val;
            CFG_END_GAIN_RIGHT:   cfg_end_r   = val;
            CFG_FRAME_COUNT:      cfg_frames  = val;
            CFG_CHANNEL_COUNT:    cfg_chans   = val[3:0];
            default: ;
        endcase
    endtask

    task automatic send_sample(input logic [15:0] smp, input bit typed, input t_pcm_out given);
        int       pct;
        t_pcm_out calc;
        pct = (idle_mode == IDLE_TX) ? 80 : (idle_mode == IDLE_BOTH) ? 13 : 0;
        if ($urandom_range(99) < pct) begin
            s_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < pct);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        do @(posedge clk); while (!s_ready);
        calc = apply_gain(smp);
        scaled_q.push_back(typed ? given : calc);
        n_words++;
    endtask

    always @(posedge clk) begin
        if (hold_req && !hold_done) begin
            m_ready  <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
        end else if (idle_mode == IDLE_RX) begin
            m_ready <= $urandom_range(99) >= 80;
        end else if (idle_mode == IDLE_BOTH) begin
            m_ready <= $urandom_range(99) >= 13;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_pcm_out want;
        if (rst_n && m_valid && m_ready) begin
            if (scaled_q.size() == 0) begin
                $error("unexpected word: sample_out %h clipped %b buffer_end %b",
                       m_data, m_clip, m_last);
                n_fail++;
            end else begin
                want = scaled_q.pop_front();
                if (m_data !== want.sample) begin
                    $error("sample_out: expected %h, got %h", want.sample, m_data);
                    n_fail++;
                end
                if (m_clip !== want.clipped) begin
                    $error("clipped: expected %b, got %b", want.clipped, m_clip);
                    n_fail++;
                end
                if (m_last !== want.buf_end) begin
                    $error("buffer_end: expected %b, got %b", want.buf_end, m_last);
                    n_fail++;
                end
                n_results++;
                if (m_clip) n_clipped++;
                if (m_last) n_ends++;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", scaled_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_row        row;
        t_pcm_out    given;
        int          ph;
        int          r;
        int          nch;
        int          len;
        logic [1:0]  mode;
        logic [15:0] frames;
        logic [3:0]  chans;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < $size(dir_rows); k++) begin
            row = dir_rows[k];
            if (row.kind == ROW_REG) begin
                if (!cfg_we) wait_quiet();
                write_reg(row.addr, row.value);
            end else begin
                cfg_we        <= 1'b0;
                given.sample  = row.exp_smp;
                given.clipped = row.exp_clip;
                given.buf_end = row.exp_last;
                send_sample(row.value, row.kind == ROW_TYPED, given);
            end
        end

        ph = 0;
        while (n_words < WORD_TARGET) begin
            wait_quiet();
            idle_mode <= t_idle'(ph % 4);

            r    = $urandom_range(9);
            mode = (r < 3) ? MODE_CONST : (r < 7) ? MODE_RAMP : (r < 9) ? MODE_MONO : MODE_PASS;
            r    = $urandom_range(19);
            case (r)
                0:       frames = 16'd0;
                1:       frames = 16'd1;
                2:       frames = 16'hFFFF;
                3:       frames = 16'($urandom);
                default: frames = 16'($urandom_range(2, 12));
            endcase
            chans = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
            if (ph == 0) begin
                mode   = MODE_RAMP;
                frames = 16'hFFFF;
            end
            if (ph == 1) chans = 4'd15;

            write_reg(CFG_GAIN_MODE, {14'd0, mode});
            write_reg(CFG_START_GAIN_LEFT, pick_gain());
            write_reg(CFG_START_GAIN_RIGHT, pick_gain());
            write_reg(CFG_END_GAIN_LEFT, pick_gain());
            write_reg(CFG_END_GAIN_RIGHT, pick_gain());
            write_reg(CFG_FRAME_COUNT, frames);
            write_reg(CFG_CHANNEL_COUNT, {12'd0, chans});
            cfg_we <= 1'b0;

            nch = chans;
            if (nch == 0) nch = 1;
            if (nch > MAX_CH) nch = MAX_CH;
            if (frames >= 1 && frames <= 12)
                len = frames * nch * $urandom_range(1, 3);
            else
                len = $urandom_range(20, 80);

            // stall the output long enough to back up the input
            if (ph == 4) begin
                hold_req <= 1'b1;
                if (len < 60) len = 60;
            end

            for (int i = 0; i < len; i++) begin
                if (ph == 2 && i == len / 2) wait_quiet();
                send_sample(pick_sample(), 1'b0, '0);
            end
            ph++;
            n_phases++;
        end

        s_valid <= 1'b0;
        while (scaled_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);

        $display("%0d samples sent over %0d random setting phases plus directed cases",
                 n_words, n_phases);
        $display("%0d results checked, %0d saturated, %0d buffer ends",
                 n_results, n_clipped, n_ends);
        if (n_fail == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
